// File: hdl/hsv_to_rgb_converter_top_macros.svh
// Assertion macros shared by the checker files of the colour converter.
// Each macro takes a label, a clock, an active-low reset, an antecedent, a consequent
// and a message string.
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Widths, fixed-point constants and shared types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int LEVEL_FRAC_BITS = 8;
    localparam int HUE_FRAC_BITS   = 4;

    localparam int HUE_W   = 13;
    localparam int LEVEL_W = 9;

    localparam int LEVEL_ONE  = 1 << LEVEL_FRAC_BITS;
    localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL   = 360 << HUE_FRAC_BITS;
    localparam int NUM_SECTORS = 6;

    // Ramp fraction f lies in 0..HUE_SECTOR.
    localparam int F_W    = $clog2(HUE_SECTOR + 1);
    localparam int PROD_W = 2 * LEVEL_W;
    localparam int NUM_W  = PROD_W + F_W;

    // The divisor LEVEL_ONE * HUE_SECTOR is 2^(frac bits + 2) times 15.
    // The power of two is taken off by a shift, the factor of 15 by a reciprocal.
    localparam int DEN         = LEVEL_ONE * HUE_SECTOR;
    localparam int HALF_DEN    = DEN / 2;
    localparam int DEN_SHIFT   = LEVEL_FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int T_W         = 12;
    localparam int RECIP       = 2185;
    localparam int RECIP_SHIFT = 15;
    localparam int Q_W         = T_W + 12;

    localparam int S_TDATA_W = ((HUE_W + 2 * LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * LEVEL_W + 7) / 8) * 8;

    localparam int HSV_FIFO_DEPTH = 4;

    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_RED_YELLOW    = 3'd0;
    localparam sector_t SECTOR_YELLOW_GREEN  = 3'd1;
    localparam sector_t SECTOR_GREEN_CYAN    = 3'd2;
    localparam sector_t SECTOR_CYAN_BLUE     = 3'd3;
    localparam sector_t SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam sector_t SECTOR_MAGENTA_RED   = 3'd5;
    localparam sector_t SECTOR_GRAY          = 3'd6;

    // One classified colour as it waits between front and back.
    typedef struct packed {
        logic                 out_of_range;
        sector_t              sector;
        logic [F_W-1:0]       ramp;
        logic [PROD_W-1:0]    prod;
        logic [LEVEL_W-1:0]   brightness;
    } item_t;

endpackage

// File: hdl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front
// Accepts colours, checks ranges, finds the hue sector and ramp, forms v*s.
// ----------------------------------------------------------------------------
module hsv_front
    import hsv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [HUE_W-1:0]   hue,
    input  logic [LEVEL_W-1:0] saturation,
    input  logic [LEVEL_W-1:0] brightness,
    output logic               item_valid,
    output item_t              item,
    input  logic               queue_full
);

    logic                  valid_reg;
    logic                  valid_next;
    item_t                 item_reg;
    item_t                 item_c;
    logic [NUM_SECTORS:1]  above;
    sector_t               sector_c;
    logic [HUE_W-1:0]      base_c;
    logic [HUE_W-1:0]      offset_c;
    logic                  push;
    logic                  accept;

    always_comb
    begin
        for (int k = 1; k <= NUM_SECTORS; k++)
        begin
            above[k] = (hue >= HUE_W'(k * HUE_SECTOR));
        end
        sector_c = '0;
        for (int k = 1; k <= NUM_SECTORS; k++)
        begin
            sector_c = sector_c + sector_t'(above[k]);
        end
        base_c   = HUE_W'(sector_c * HUE_W'(HUE_SECTOR));
        offset_c = hue - base_c;

        item_c.out_of_range = (hue > HUE_W'(HUE_FULL)) || (saturation > LEVEL_W'(LEVEL_ONE))
                              || (brightness > LEVEL_W'(LEVEL_ONE));
        item_c.sector       = sector_c;
        // Odd sectors ramp down, even sectors ramp up.
        item_c.ramp         = sector_c[0] ? F_W'(HUE_W'(HUE_SECTOR) - offset_c)
                                          : F_W'(offset_c);
        item_c.prod         = PROD_W'(brightness) * PROD_W'(saturation);
        item_c.brightness   = brightness;
    end

    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_c;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/hsv_fifo.sv
// ----------------------------------------------------------------------------
// hsv_fifo
// Short queue of classified colours between the front and the back.
// ----------------------------------------------------------------------------
module hsv_fifo
    import hsv_pkg::*;
#(
    parameter int DEPTH = HSV_FIFO_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/hsv_back.sv
// ----------------------------------------------------------------------------
// hsv_back
// Three-stage pipeline: chroma and ramp product, reciprocal divide, component
// selection into the output register.
// ----------------------------------------------------------------------------
module hsv_back
    import hsv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] red,
    output logic [LEVEL_W-1:0] green,
    output logic [LEVEL_W-1:0] blue,
    output logic               out_of_range
);

    // Stage one registers
    logic               s1_valid_reg;
    logic               s1_oor_reg;
    sector_t            s1_sector_reg;
    logic [LEVEL_W-1:0] s1_v_reg;
    logic [LEVEL_W-1:0] s1_m_reg;
    logic [T_W-1:0]     s1_t_reg;
    // Stage two registers
    logic               s2_valid_reg;
    logic               s2_oor_reg;
    sector_t            s2_sector_reg;
    logic [LEVEL_W-1:0] s2_v_reg;
    logic [LEVEL_W-1:0] s2_m_reg;
    logic [Q_W-1:0]     s2_q_reg;
    // Output registers
    logic               out_valid_reg;
    logic               out_oor_reg;
    logic [LEVEL_W-1:0] red_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] blue_reg;

    logic               out_load;
    logic               s2_load;
    logic               s1_load;
    logic [PROD_W-1:0]  c_sum;
    logic [LEVEL_W-1:0] chroma;
    logic [NUM_W-1:0]   num;
    logic [LEVEL_W-1:0] x_c;
    logic [LEVEL_W:0]   xm_wide;
    logic [LEVEL_W-1:0] xm_c;
    logic [LEVEL_W-1:0] red_c;
    logic [LEVEL_W-1:0] green_c;
    logic [LEVEL_W-1:0] blue_c;

    assign out_load = !out_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || out_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign item_pop = s1_load && item_valid;

    // Stage one: chroma with rounding, offset m, and the ramp product with the
    // power-of-two part of the divisor removed.
    always_comb
    begin
        c_sum  = item.prod + PROD_W'(LEVEL_ONE / 2);
        chroma = c_sum[LEVEL_FRAC_BITS +: LEVEL_W];
        num    = NUM_W'(item.prod) * NUM_W'(item.ramp) + NUM_W'(HALF_DEN);
    end

    // Stage three: finish the divide by 15 by shifting the reciprocal product, then place the components.
    always_comb
    begin
        x_c     = s2_q_reg[RECIP_SHIFT +: LEVEL_W];
        xm_wide = {1'b0, x_c} + {1'b0, s2_m_reg};
        xm_c    = xm_wide[LEVEL_W-1:0];
        red_c   = s2_m_reg;
        green_c = s2_m_reg;
        blue_c  = s2_m_reg;
        unique case (s2_sector_reg)
            SECTOR_RED_YELLOW:
            begin
                red_c   = s2_v_reg;
                green_c = xm_c;
            end
            SECTOR_YELLOW_GREEN:
            begin
                red_c   = xm_c;
                green_c = s2_v_reg;
            end
            SECTOR_GREEN_CYAN:
            begin
                green_c = s2_v_reg;
                blue_c  = xm_c;
            end
            SECTOR_CYAN_BLUE:
            begin
                green_c = xm_c;
                blue_c  = s2_v_reg;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                red_c   = xm_c;
                blue_c  = s2_v_reg;
            end
            SECTOR_MAGENTA_RED:
            begin
                red_c   = s2_v_reg;
                blue_c  = xm_c;
            end
            default:
            begin
                red_c   = s2_m_reg;
            end
        endcase
        if (s2_oor_reg)
        begin
            red_c   = '0;
            green_c = '0;
            blue_c  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_oor_reg    <= item.out_of_range;
            s1_sector_reg <= item.sector;
            s1_v_reg      <= item.brightness;
            s1_m_reg      <= item.brightness - chroma;
            s1_t_reg      <= num[DEN_SHIFT +: T_W];
        end
        if (s2_load)
        begin
            s2_oor_reg    <= s1_oor_reg;
            s2_sector_reg <= s1_sector_reg;
            s2_v_reg      <= s1_v_reg;
            s2_m_reg      <= s1_m_reg;
            s2_q_reg      <= Q_W'(s1_t_reg) * Q_W'(RECIP);
        end
        if (out_load)
        begin
            out_oor_reg <= s2_oor_reg;
            red_reg     <= red_c;
            green_reg   <= green_c;
            blue_reg    <= blue_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_of_range = out_oor_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

endmodule

// File: hdl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Converts fixed-point HSV colours to RGB, one colour per clock while results are taken.
// ----------------------------------------------------------------------------
// The slave stream carries one colour per transaction: hue in 1/16 degree,
// saturation and value with 256 meaning 1.0. The master stream returns one
// transaction per colour with red, green and blue on tdata and the
// out-of-range flag on tuser; out-of-range inputs come back black.
// A hue of exactly 360 degrees gives a grey at the offset level.
// A result passes through the front register, one queue slot and the three
// back stages (chroma and ramp product, divide by reciprocal, component
// selection into the output register) before it can first be taken.
// Throughput is one colour per cycle while m_tready stays high; every stage is
// fully pipelined and the three multipliers sit in separate stages.
// When the master side stalls, the back stages fill, then the queue, then
// the front register, and only then is s_tready dropped.
// Reset empties the queue and all pipeline stages; no results are held.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsv_pkg::*;
#(
    parameter int FIFO_DEPTH = HSV_FIFO_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // hue [12:0], saturation [21:13], brightness [30:22], zero above
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // red [8:0], green [17:9], blue [26:18], zero above
    output logic [M_TDATA_W-1:0] m_tdata,
    // out_of_range [0]
    output logic                 m_tuser
);

    logic               front_valid;
    item_t              front_item;
    logic               queue_full;
    logic               queue_not_empty;
    item_t              queue_item;
    logic               queue_pop;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;

    hsv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[HUE_W-1:0]),
        .saturation (s_tdata[HUE_W +: LEVEL_W]),
        .brightness (s_tdata[HUE_W + LEVEL_W +: LEVEL_W]),
        .item_valid (front_valid),
        .item       (front_item),
        .queue_full (queue_full)
    );

    hsv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    hsv_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (queue_not_empty),
        .item         (queue_item),
        .item_pop     (queue_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_of_range (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({blue, green, red});

endmodule

// File: hdl/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_checker
    import hsv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    logic inputs_seen;
    logic levels_ok;

    assign inputs_seen = s_tvalid || s_tready || (s_tdata != '0);
    assign levels_ok   = (m_tdata[LEVEL_W-1:0] <= LEVEL_W'(LEVEL_ONE))
                         && (m_tdata[LEVEL_W +: LEVEL_W] <= LEVEL_W'(LEVEL_ONE))
                         && (m_tdata[2*LEVEL_W +: LEVEL_W] <= LEVEL_W'(LEVEL_ONE))
                         && (m_tdata[M_TDATA_W-1:3*LEVEL_W] == '0);

    // A stalled result must stay put until it is taken.
    `HSV_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A flagged colour is always black.
    `HSV_ASSERT_SAME(a_oor_black, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "flagged result is not black")

    // No component exceeds full scale and the padding stays clear.
    `HSV_ASSERT_SAME(a_levels, clk, rst_n, m_tvalid || inputs_seen, !m_tvalid || levels_ok, "component above full scale")

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (.*);
